// ===== hdl/midpoint_ellipse_rasterizer_unit_macros.svh =====
// assertion macros for the midpoint ellipse rasterizer
// no dependencies; taken in by the top level
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_UNIT_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MER_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rasterizer same-cycle check failed");
`define MER_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rasterizer next-cycle check failed");
`else
`define MER_ASSERT_SAME(label, clk, rst, cond, prop)
`define MER_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== hdl/mer_pkg.sv =====
// shared types and constants of the midpoint ellipse rasterizer
// no dependencies; used by controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 10;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [3:0] {
    ST_READY,
    ST_START_RXSQ,
    ST_START_RYSQ,
    ST_START_CROSS,
    ST_START_LOAD,
    ST_START_SETTLE,
    ST_REGION_TSQ,
    ST_REGION_YSQ,
    ST_REGION_A,
    ST_REGION_B,
    ST_REGION_C,
    ST_REGION_D
  } ctrl_state_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RXRX,
    MUL_RYRY,
    MUL_RX2RY,
    MUL_TT,
    MUL_YMYM,
    MUL_RY2T2,
    MUL_RX2Y2,
    MUL_RX2RY2
  } mul_sel_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_RX2,
    WB_RY2,
    WB_START_LOAD,
    WB_CONSTS,
    WB_T2,
    WB_Y2,
    WB_DEC_SET,
    WB_DEC_ADD,
    WB_DEC_SUB
  } wb_sel_t;

  typedef struct packed {
    logic     start;
    logic     step;
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
    logic     enter_r2;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic step_enter;
    logic gap_nonneg;
    logic out_block;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/mer_ctrl.sv =====
// sequencing controller of the midpoint ellipse rasterizer
// depends on mer_pkg; drives the datapath through cmd_t
`timescale 1ns / 1ps
`default_nettype none

module mer_ctrl import mer_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  input  wire logic    req_type,
  output logic         req_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;

  assign req_stall = (state != ST_READY) || status.out_block;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_READY: begin
        if (accept && req_type == REQ_START) begin
          state_next = ST_START_RXSQ;
        end else if (accept && req_type == REQ_STEP && status.step_enter) begin
          state_next = ST_REGION_TSQ;
        end
      end
      ST_START_RXSQ:   state_next = ST_START_RYSQ;
      ST_START_RYSQ:   state_next = ST_START_CROSS;
      ST_START_CROSS:  state_next = ST_START_LOAD;
      ST_START_LOAD:   state_next = ST_START_SETTLE;
      ST_START_SETTLE: state_next = status.gap_nonneg ? ST_REGION_TSQ : ST_READY;
      ST_REGION_TSQ:   state_next = ST_REGION_YSQ;
      ST_REGION_YSQ:   state_next = ST_REGION_A;
      ST_REGION_A:     state_next = ST_REGION_B;
      ST_REGION_B:     state_next = ST_REGION_C;
      ST_REGION_C:     state_next = ST_REGION_D;
      ST_REGION_D:     state_next = ST_READY;
      default:         state_next = ST_READY;
    endcase
  end

  always_comb begin
    cmd = '{start: 1'b0, step: 1'b0, mul_sel: MUL_NONE, wb_sel: WB_NONE, enter_r2: 1'b0};
    case (state)
      ST_READY: begin
        cmd.start = accept && req_type == REQ_START;
        cmd.step  = accept && req_type == REQ_STEP;
      end
      ST_START_RXSQ: cmd.mul_sel = MUL_RXRX;
      ST_START_RYSQ: begin
        cmd.mul_sel = MUL_RYRY;
        cmd.wb_sel  = WB_RX2;
      end
      ST_START_CROSS: begin
        cmd.mul_sel = MUL_RX2RY;
        cmd.wb_sel  = WB_RY2;
      end
      ST_START_LOAD: cmd.wb_sel = WB_START_LOAD;
      ST_START_SETTLE: begin
        cmd.wb_sel   = WB_CONSTS;
        cmd.enter_r2 = status.gap_nonneg;
      end
      ST_REGION_TSQ: cmd.mul_sel = MUL_TT;
      ST_REGION_YSQ: begin
        cmd.mul_sel = MUL_YMYM;
        cmd.wb_sel  = WB_T2;
      end
      ST_REGION_A: begin
        cmd.mul_sel = MUL_RY2T2;
        cmd.wb_sel  = WB_Y2;
      end
      ST_REGION_B: begin
        cmd.mul_sel = MUL_RX2Y2;
        cmd.wb_sel  = WB_DEC_SET;
      end
      ST_REGION_C: begin
        cmd.mul_sel = MUL_RX2RY2;
        cmd.wb_sel  = WB_DEC_ADD;
      end
      ST_REGION_D: cmd.wb_sel = WB_DEC_SUB;
      default: cmd.wb_sel = WB_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/mer_datapath.sv =====
// datapath of the midpoint ellipse rasterizer: offsets, slopes, decision,
// shared multiplier and output register; depends on mer_pkg, driven by mer_ctrl
`timescale 1ns / 1ps
`default_nettype none

module mer_datapath import mer_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic signed [COORD_BITS-1:0]  center_x,
  input  wire logic signed [COORD_BITS-1:0]  center_y,
  input  wire logic        [RADIUS_BITS-1:0] radius_x,
  input  wire logic        [RADIUS_BITS-1:0] radius_y,
  input  wire cmd_t                          cmd,
  input  wire logic                          pix_stall,
  output logic                               pix_valid,
  output logic signed [COORD_BITS:0]         right_x,
  output logic signed [COORD_BITS:0]         left_x,
  output logic signed [COORD_BITS:0]         lower_y,
  output logic signed [COORD_BITS:0]         upper_y,
  output logic                               last,
  output status_t                            status
);

  localparam int XW  = RADIUS_BITS + 1;
  localparam int YW  = RADIUS_BITS + 2;
  localparam int SQW = 2 * RADIUS_BITS;
  localparam int TW  = 2 * RADIUS_BITS + 4;
  localparam int MA  = 2 * RADIUS_BITS + 1;
  localparam int MB  = TW + 1;
  localparam int PW  = MA + MB;
  localparam int SLW = 3 * RADIUS_BITS + 3;
  localparam int DW  = 4 * RADIUS_BITS + 8;
  localparam int OW  = COORD_BITS + 1;
  localparam logic signed [YW-1:0] YONE = YW'(1);
  localparam logic        [XW-1:0] XONE = XW'(1);

  // stored state
  logic signed [COORD_BITS-1:0]  cx;
  logic signed [COORD_BITS-1:0]  cy;
  logic        [RADIUS_BITS-1:0] rx;
  logic        [RADIUS_BITS-1:0] ry;
  logic        [SQW-1:0]         rx2;
  logic        [SQW-1:0]         ry2;
  logic        [TW-1:0]          t2;
  logic        [TW-1:0]          y2;
  logic signed [PW-1:0]          prod;
  logic        [XW-1:0]          x;
  logic signed [YW-1:0]          y;
  logic signed [SLW-1:0]         sx;
  logic signed [SLW-1:0]         sy;
  logic signed [SLW-1:0]         gap;
  logic signed [SLW-1:0]         two_sum;
  logic signed [DW-1:0]          d;
  logic signed [DW-1:0]          k_a;
  logic signed [DW-1:0]          k_b;
  logic signed [DW-1:0]          k_c;
  logic signed [DW-1:0]          k_d;
  logic                          busy;
  logic                          r2;

  // combinational
  logic signed [MA-1:0]          mul_a;
  logic signed [MB-1:0]          mul_b;
  logic        [RADIUS_BITS+1:0] t;
  logic signed [YW-1:0]          ym;
  logic signed [SLW-1:0]         two_rx2;
  logic signed [SLW-1:0]         two_ry2;
  logic signed [SLW-1:0]         sy_init;
  logic signed [DW-1:0]          rx2_d;
  logic signed [DW-1:0]          ry2_d;
  logic signed [DW-1:0]          prod_d;
  logic signed [DW-1:0]          sx_d;
  logic signed [DW-1:0]          sy_d;
  logic signed [DW-1:0]          gap_d;
  logic        [XW-1:0]          x_next;
  logic signed [YW-1:0]          y_next;
  logic signed [SLW-1:0]         sx_next;
  logic signed [SLW-1:0]         sy_next;
  logic signed [SLW-1:0]         gap_next;
  logic signed [DW-1:0]          d_next;
  logic                          r2_next;
  logic                          last_next;
  logic                          step_go;
  logic signed [OW-1:0]          cx_o;
  logic signed [OW-1:0]          cy_o;
  logic signed [OW-1:0]          x_o;
  logic signed [OW-1:0]          y_o;

  assign t       = {x, 1'b1};
  assign ym      = y - YONE;
  assign two_rx2 = {{(SLW-SQW-1){1'b0}}, rx2, 1'b0};
  assign two_ry2 = {{(SLW-SQW-1){1'b0}}, ry2, 1'b0};
  assign sy_init = {prod[SLW-2:0], 1'b0};
  assign rx2_d   = {{(DW-SQW){1'b0}}, rx2};
  assign ry2_d   = {{(DW-SQW){1'b0}}, ry2};
  assign prod_d  = {{(DW-PW){prod[PW-1]}}, prod};
  assign sx_d    = {{(DW-SLW){sx[SLW-1]}}, sx};
  assign sy_d    = {{(DW-SLW){sy[SLW-1]}}, sy};
  assign gap_d   = {{(DW-SLW){gap[SLW-1]}}, gap};
  assign step_go = cmd.step && busy;

  assign cx_o = OW'(cx);
  assign cy_o = OW'(cy);
  assign x_o  = OW'(x);
  assign y_o  = OW'(y);

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_RXRX: begin
        mul_a = {{(MA-RADIUS_BITS){1'b0}}, rx};
        mul_b = {{(MB-RADIUS_BITS){1'b0}}, rx};
      end
      MUL_RYRY: begin
        mul_a = {{(MA-RADIUS_BITS){1'b0}}, ry};
        mul_b = {{(MB-RADIUS_BITS){1'b0}}, ry};
      end
      MUL_RX2RY: begin
        mul_a = {1'b0, rx2};
        mul_b = {{(MB-RADIUS_BITS){1'b0}}, ry};
      end
      MUL_TT: begin
        mul_a = {{(MA-RADIUS_BITS-2){1'b0}}, t};
        mul_b = {{(MB-RADIUS_BITS-2){1'b0}}, t};
      end
      MUL_YMYM: begin
        mul_a = {{(MA-YW){ym[YW-1]}}, ym};
        mul_b = {{(MB-YW){ym[YW-1]}}, ym};
      end
      MUL_RY2T2: begin
        mul_a = {1'b0, ry2};
        mul_b = {1'b0, t2};
      end
      MUL_RX2Y2: begin
        mul_a = {1'b0, rx2};
        mul_b = {1'b0, y2};
      end
      MUL_RX2RY2: begin
        mul_a = {1'b0, rx2};
        mul_b = {{(MB-SQW){1'b0}}, ry2};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // one pixel step of the midpoint recurrence
  always_comb begin
    x_next   = x;
    y_next   = y;
    sx_next  = sx;
    sy_next  = sy;
    gap_next = gap;
    d_next   = d;
    r2_next  = r2;
    if (!r2) begin
      x_next  = x + XONE;
      sx_next = sx + two_ry2;
      if (d[DW-1]) begin
        gap_next = gap + two_ry2;
        d_next   = d + (sx_d <<< 2) + k_a;
      end else begin
        y_next   = y - YONE;
        sy_next  = sy - two_rx2;
        gap_next = gap + two_sum;
        d_next   = d + (gap_d <<< 2) + k_b;
      end
      r2_next = !gap_next[SLW-1];
    end else begin
      y_next  = y - YONE;
      sy_next = sy - two_rx2;
      if (!d[DW-1] && d != '0) begin
        gap_next = gap + two_rx2;
        d_next   = d - (sy_d <<< 2) + k_c;
      end else begin
        x_next   = x + XONE;
        sx_next  = sx + two_ry2;
        gap_next = gap + two_sum;
        d_next   = d + (gap_d <<< 2) + k_d;
      end
    end
    last_next = r2_next && y_next[YW-1];
  end

  assign status.busy       = busy;
  assign status.step_enter = busy && !r2 && r2_next && !last_next;
  assign status.gap_nonneg = !gap[SLW-1];
  assign status.out_block  = pix_valid && pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      r2        <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        busy <= 1'b1;
        r2   <= 1'b0;
      end else if (step_go) begin
        busy <= !last_next;
        r2   <= r2_next;
      end
      if (cmd.enter_r2) begin
        r2 <= 1'b1;
      end
      pix_valid <= step_go || (pix_valid && pix_stall);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.start) begin
      cx <= center_x;
      cy <= center_y;
      rx <= radius_x;
      ry <= radius_y;
      x  <= '0;
      y  <= {2'b00, radius_y};
      sx <= '0;
    end
    if (step_go) begin
      right_x <= cx_o + x_o;
      left_x  <= cx_o - x_o;
      lower_y <= cy_o + y_o;
      upper_y <= cy_o - y_o;
      last    <= last_next;
      x       <= x_next;
      y       <= y_next;
      sx      <= sx_next;
      sy      <= sy_next;
      gap     <= gap_next;
      d       <= d_next;
    end
    case (cmd.wb_sel)
      WB_RX2: rx2 <= prod[SQW-1:0];
      WB_RY2: ry2 <= prod[SQW-1:0];
      WB_START_LOAD: begin
        sy  <= sy_init;
        gap <= -sy_init;
        d   <= (ry2_d <<< 2) - (prod_d <<< 2) + rx2_d;
        k_a <= (ry2_d <<< 3) + (ry2_d <<< 2);
        k_c <= (rx2_d <<< 3) + (rx2_d <<< 2);
      end
      WB_CONSTS: begin
        k_b     <= k_a + (rx2_d <<< 3);
        k_d     <= k_c + (ry2_d <<< 3);
        two_sum <= two_rx2 + two_ry2;
      end
      WB_T2:      t2 <= prod[TW-1:0];
      WB_Y2:      y2 <= prod[TW-1:0];
      WB_DEC_SET: d <= prod_d;
      WB_DEC_ADD: d <= d + (prod_d <<< 2);
      WB_DEC_SUB: d <= d - (prod_d <<< 2);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/midpoint_ellipse_rasterizer_unit.sv =====
// Midpoint ellipse rasterizer, top level.
// Request channel (req_valid/req_stall): req_type selects start or step; a start
// transaction latches center_x, center_y, radius_x and radius_y, a step transaction
// asks for the next set of four symmetric pixels.
// Pixel channel (pix_valid/pix_stall): right_x, left_x, lower_y, upper_y and last,
// last high on the final set of the ellipse.
// A start holds req_stall in ST_START_RXSQ to ST_START_SETTLE while the shared
// multiplier forms the squared radii, the slope terms and the decision variable,
// and in ST_REGION_TSQ to ST_REGION_D too when the ellipse begins in region two.
// Steps run at one per cycle; a set reaches the pixel channel in the cycle after
// its step transaction. The switch from region one to region two stalls requests
// in ST_REGION_TSQ to ST_REGION_D for the recomputed decision on the same
// multiplier. A step while no ellipse is active is taken and gives nothing.
// A held pixel transaction stays in the output register; a further step is taken
// only when that register is free or emptied in the same cycle.
// Reset leaves the block idle with an empty output register.
// depends on mer_pkg, mer_ctrl, mer_datapath and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "midpoint_ellipse_rasterizer_unit_macros.svh"

module midpoint_ellipse_rasterizer_unit import mer_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic                          req_type,
  input  wire logic signed [COORD_BITS-1:0]  center_x,
  input  wire logic signed [COORD_BITS-1:0]  center_y,
  input  wire logic        [RADIUS_BITS-1:0] radius_x,
  input  wire logic        [RADIUS_BITS-1:0] radius_y,
  output logic                               pix_valid,
  input  wire logic                          pix_stall,
  output logic signed [COORD_BITS:0]         right_x,
  output logic signed [COORD_BITS:0]         left_x,
  output logic signed [COORD_BITS:0]         lower_y,
  output logic signed [COORD_BITS:0]         upper_y,
  output logic                               last
);

  cmd_t    cmd;
  status_t status;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mer_datapath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius_x  (radius_x),
    .radius_y  (radius_y),
    .cmd       (cmd),
    .pix_stall (pix_stall),
    .pix_valid (pix_valid),
    .right_x   (right_x),
    .left_x    (left_x),
    .lower_y   (lower_y),
    .upper_y   (upper_y),
    .last      (last),
    .status    (status)
  );

  `MER_ASSERT_SAME(a_mul_blocks_req, clk, rst, cmd.mul_sel != MUL_NONE, req_stall)
  `MER_ASSERT_NEXT(a_step_gives_pix, clk, rst, cmd.step && status.busy, pix_valid)
  `MER_ASSERT_NEXT(a_start_runs_seq, clk, rst, cmd.start, req_stall && status.busy)

endmodule

`default_nettype wire

// ===== tb/midpoint_ellipse_rasterizer_unit_tb.sv =====
// self-checking bench for midpoint_ellipse_rasterizer_unit: directed table then random ellipses
// expected point sets: in-bench integer ellipse predictor or directed table; depends on mer_pkg
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_unit_tb;
  import mer_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int RB = RADIUS_BITS_DEF;
  localparam int PB = CB + 1;
  localparam int ITEM_TARGET = 1700;

  typedef struct {
    logic                 typ;
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic [RB-1:0]        rx;
    logic [RB-1:0]        ry;
  } ellipse_req_t;

  typedef struct {
    logic signed [PB-1:0] right_x;
    logic signed [PB-1:0] left_x;
    logic signed [PB-1:0] lower_y;
    logic signed [PB-1:0] upper_y;
    logic                 fin;
  } pixset_t;

  typedef struct {
    logic typ;
    int   cx, cy, rx, ry;
    bit   typed;
    int   r, l, lo, up;
    bit   fin;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_type = REQ_STEP;
  logic signed [CB-1:0] center_x = '0;
  logic signed [CB-1:0] center_y = '0;
  logic [RB-1:0] radius_x = '0;
  logic [RB-1:0] radius_y = '0;
  logic pix_stall = 1'b0;
  wire req_stall;
  wire pix_valid;
  wire signed [PB-1:0] right_x, left_x, lower_y, upper_y;
  wire last;

  midpoint_ellipse_rasterizer_unit DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .center_x(center_x), .center_y(center_y), .radius_x(radius_x), .radius_y(radius_y),
    .pix_valid(pix_valid), .pix_stall(pix_stall),
    .right_x(right_x), .left_x(left_x), .lower_y(lower_y), .upper_y(upper_y),
    .last(last)
  );

  always #4 clk = ~clk;

  // predictor state
  longint ctr_col, ctr_row, rx_sq, ry_sq, off_x, off_y, slope_x, slope_y, dvar;
  bit in_r2, drawing;

  pixset_t pix_expected[$];
  int n_err, n_starts, n_sets_sent, n_ignored, n_checked, n_done;
  int burst_left, gap;

  function automatic void settle_region();
    longint t, ym;
    if (!in_r2 && slope_x >= slope_y) begin
      t = 2 * off_x + 1;
      ym = off_y - 1;
      in_r2 = 1'b1;
      dvar = ry_sq * t * t + 4 * rx_sq * ym * ym - 4 * rx_sq * ry_sq;
    end
    if (in_r2 && off_y < 0) drawing = 1'b0;
  endfunction

  function automatic bit apply_req(input ellipse_req_t rq, output pixset_t p);
    longint lrx, lry;
    p = '{default: '0};
    if (rq.typ == REQ_START) begin
      lrx = rq.rx;
      lry = rq.ry;
      ctr_col = rq.cx;
      ctr_row = rq.cy;
      rx_sq = lrx * lrx;
      ry_sq = lry * lry;
      off_x = 0;
      off_y = lry;
      slope_x = 0;
      slope_y = 2 * rx_sq * lry;
      dvar = 4 * ry_sq - 4 * rx_sq * lry + rx_sq;
      in_r2 = 1'b0;
      drawing = 1'b1;
      settle_region();
      return 1'b0;
    end
    if (!drawing) return 1'b0;
    p.right_x = PB'(ctr_col + off_x);
    p.left_x  = PB'(ctr_col - off_x);
    p.lower_y = PB'(ctr_row + off_y);
    p.upper_y = PB'(ctr_row - off_y);
    if (!in_r2) begin
      off_x++;
      slope_x += 2 * ry_sq;
      if (dvar < 0) begin
        dvar += 4 * (slope_x + ry_sq);
      end else begin
        off_y--;
        slope_y -= 2 * rx_sq;
        dvar += 4 * (slope_x - slope_y + ry_sq);
      end
    end else begin
      off_y--;
      slope_y -= 2 * rx_sq;
      if (dvar > 0) begin
        dvar += 4 * (rx_sq - slope_y);
      end else begin
        off_x++;
        slope_x += 2 * ry_sq;
        dvar += 4 * (slope_x - slope_y + rx_sq);
      end
    end
    settle_region();
    p.fin = !drawing;
    return 1'b1;
  endfunction

  // drive one request transaction, with burst gaps, and wait for it to be taken
  task automatic push_req(input ellipse_req_t rq);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req_type  <= rq.typ;
    center_x  <= rq.cx;
    center_y  <= rq.cy;
    radius_x  <= rq.rx;
    radius_y  <= rq.ry;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic issue(input ellipse_req_t rq);
    pixset_t ps;
    push_req(rq);
    if (apply_req(rq, ps)) begin
      pix_expected.push_back(ps);
      n_sets_sent++;
    end else if (rq.typ == REQ_START) begin
      n_starts++;
    end else begin
      n_ignored++;
    end
  endtask

  function automatic void cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    pixset_t e;
    if (!rst && pix_valid && !pix_stall) begin
      if (pix_expected.size() == 0) begin
        n_err++;
        $display("%0t: point set with none expected: %0d %0d %0d %0d last %0d",
                 $time, right_x, left_x, lower_y, upper_y, last);
      end else begin
        e = pix_expected.pop_front();
        cmp_field("right_x", e.right_x, right_x);
        cmp_field("left_x", e.left_x, left_x);
        cmp_field("lower_y", e.lower_y, lower_y);
        cmp_field("upper_y", e.upper_y, upper_y);
        cmp_field("last", e.fin, last);
        n_checked++;
        if (last) n_done++;
      end
    end
  end

  // receiver: stall pattern of its own plus two long hold-offs
  initial begin
    int cyc, hold, mode;
    logic s;
    cyc = 0;
    hold = 0;
    mode = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (cyc % 128 == 0) mode = $urandom_range(0, 3);
      if (cyc == 400 || cyc == 3000) hold = 120;
      if (hold > 0) begin
        hold--;
        s = 1'b1;
      end else begin
        case (mode)
          0: s = 1'b0;
          1: s = ($urandom_range(0, 3) == 0);
          2: s = (cyc % 3 != 0);
          default: s = ($urandom_range(0, 3) != 0);
        endcase
      end
      pix_stall <= s;
      cyc++;
      @(posedge clk);
    end
  end

  function automatic logic signed [CB-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(CB-1){1'b0}}};
      1: return {1'b0, {(CB-1){1'b1}}};
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic logic [RB-1:0] pick_small_radius();
    if ($urandom_range(0, 9) == 0) return '0;
    return RB'($urandom_range(0, 24));
  endfunction

  dir_row_t dir_tab [25] = '{
    '{REQ_STEP,      0,     0,    0,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_START,     0,     0,    0,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 1,     0,     0,     0,     0, 1},
    '{REQ_STEP,      0,     0,    0,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_START,  2047, -2048,    0,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 1,  2047,  2047, -2048, -2048, 1},
    '{REQ_START, -2048,  2047, 1023,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 1, -2048, -2048,  2047,  2047, 1},
    '{REQ_START,     0,     0,    0,    3, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 1,     0,     0,     3,    -3, 0},
    '{REQ_STEP,      0,     0,    0,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,   -1,      -1, 1023, 1023, 0,     0,     0,     0,     0, 0},
    '{REQ_START,  2047,  2047, 1023, 1023, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 1,  2047,  2047,  3070,  1024, 0},
    '{REQ_STEP,      0,     0,    0,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_START, -2048, -2048, 1023, 1023, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 1, -2048, -2048, -1025, -3071, 0},
    '{REQ_START,     5,    -7,    3,    2, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 0,     0,     0,     0,     0, 0},
    '{REQ_STEP,      0,     0,    0,    0, 0,     0,     0,     0,     0, 0}
  };

  initial begin
    ellipse_req_t rq;
    pixset_t tp;
    int cut, taken, before_sets;
    n_err = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_tab[i]) begin
      rq.typ = dir_tab[i].typ;
      rq.cx = CB'(dir_tab[i].cx);
      rq.cy = CB'(dir_tab[i].cy);
      rq.rx = RB'(dir_tab[i].rx);
      rq.ry = RB'(dir_tab[i].ry);
      before_sets = n_sets_sent;
      issue(rq);
      if (dir_tab[i].typed && n_sets_sent != before_sets) begin
        tp.right_x = PB'(dir_tab[i].r);
        tp.left_x  = PB'(dir_tab[i].l);
        tp.lower_y = PB'(dir_tab[i].lo);
        tp.upper_y = PB'(dir_tab[i].up);
        tp.fin     = dir_tab[i].fin;
        pix_expected[pix_expected.size() - 1] = tp;
      end
    end

    // random ellipses, mostly run to the end, some cut short by a restart
    while (n_starts + n_sets_sent < ITEM_TARGET) begin
      rq.typ = REQ_START;
      rq.cx = pick_coord();
      rq.cy = pick_coord();
      if ($urandom_range(0, 9) == 0) begin
        rq.rx = RB'($urandom_range(0, 1023));
        rq.ry = RB'($urandom_range(0, 1023));
        cut = $urandom_range(0, 150);
      end else begin
        rq.rx = pick_small_radius();
        rq.ry = pick_small_radius();
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : 1 << 30;
      end
      issue(rq);
      taken = 0;
      while (drawing && taken < cut) begin
        rq.typ = REQ_STEP;
        rq.cx = CB'($urandom);
        rq.cy = CB'($urandom);
        rq.rx = RB'($urandom);
        rq.ry = RB'($urandom);
        issue(rq);
        taken++;
      end
      if (!drawing && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          rq.typ = REQ_STEP;
          rq.cx = CB'($urandom);
          rq.cy = CB'($urandom);
          issue(rq);
        end
      end
    end

    req_valid <= 1'b0;
    while (pix_expected.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d starts, %0d step requests and %0d ignored steps",
             n_starts, n_sets_sent, n_ignored);
    $display("checked %0d point sets, %0d ellipses drawn to their final set",
             n_checked, n_done);
    if (n_err == 0) begin
      $display("midpoint_ellipse_rasterizer_unit_tb OK");
    end else begin
      $display("midpoint_ellipse_rasterizer_unit_tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("timeout with %0d point sets outstanding", pix_expected.size());
    $display("midpoint_ellipse_rasterizer_unit_tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mer_pkg.sv
hdl/mer_ctrl.sv
hdl/mer_datapath.sv
hdl/midpoint_ellipse_rasterizer_unit.sv
tb/midpoint_ellipse_rasterizer_unit_tb.sv
